// ===== sv/phxv_pkg.sv =====
package phxv_pkg;

   localparam int MAX_FRAME_BYTES_DEFAULT = 64;
   localparam int HEADER_BYTES            = 7;
   localparam int CHECK_POS               = 6;

   localparam int POS_MAGIC    = 0;
   localparam int POS_VERSION  = 1;
   localparam int POS_TYPE     = 2;
   localparam int POS_SEQUENCE = 3;
   localparam int POS_LEN_LO   = 4;
   localparam int POS_LEN_HI   = 5;

   localparam logic [7:0] MAGIC_RESET   = 8'hCF;
   localparam logic [7:0] VERSION_RESET = 8'h01;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   typedef enum logic [0:0] {
      CSR_EXPECTED_MAGIC   = 1'b0,
      CSR_EXPECTED_VERSION = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_TOO_SHORT   = 3'd1,
      STATUS_BAD_MAGIC   = 3'd2,
      STATUS_BAD_VERSION = 3'd3,
      STATUS_TRUNCATED   = 3'd4,
      STATUS_BAD_CHECK   = 3'd5
   } status_type;

endpackage

// ===== sv/packet_header_xor_validator.sv =====
// framed packet header check with xor checksum
//
// req channel: one received byte per transfer, req_frame_end set on the last
// byte of a frame. only the first MAX_FRAME_BYTES bytes of a frame are kept.
// the first seven kept bytes are the header: magic, version, type, sequence,
// payload length (low, high) and check byte.
// rsp channel: one verdict per frame, with the header fields and the number
// of kept bytes. status is checked in order: too short, bad magic, bad
// version, truncated, checksum mismatch.
// csr port: expected_magic at 0x0, expected_version at 0x4, 8 bits each.
// throughput: one byte per cycle while req_ready is high, set by the single
// frame register update stage. the last byte loads the verdict register.
// the result register holds a verdict while rsp_ready is low; req_ready then
// stays low, so no byte is taken until the verdict is transferred.
// reset: frame state clears, expected_magic returns to 0xCF and
// expected_version to 0x01; no verdict is pending after reset.
module packet_header_xor_validator
   import phxv_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_rx_byte,
   input  logic                      req_frame_end,

   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [2:0]                rsp_status,
   output logic [7:0]                rsp_msg_type,
   output logic [7:0]                rsp_seq_number,
   output logic [15:0]               rsp_payload_length,
   output logic [6:0]                rsp_frame_bytes,

   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   localparam int IW   = $clog2(MAX_FRAME_BYTES + 1);
   localparam int EXTW = IW + 7;

   logic [7:0]    magic_cfg_ff, version_cfg_ff;
   csr_index_type csr_index;

   logic [IW-1:0] byte_index_ff, byte_index_in;
   logic [7:0]    magic_ff, magic_in;
   logic [7:0]    version_ff, version_in;
   logic [7:0]    type_ff, type_in;
   logic [7:0]    sequence_ff, sequence_in;
   logic [15:0]   length_ff, length_in;
   logic [7:0]    check_ff, check_in;
   logic [7:0]    xor_ff, xor_in;

   logic          rsp_valid_ff, rsp_valid_in;
   status_type    status_ff, status_in;
   logic [7:0]    rsp_type_ff;
   logic [7:0]    rsp_seq_ff;
   logic [15:0]   rsp_length_ff;
   logic [6:0]    rsp_bytes_ff;

   logic          req_fire, last_fire, take, in_sum;
   logic [16:0]   index_ext, count_ext;
   logic [EXTW-1:0] bytes_ext;

   // config registers
   assign csr_index  = csr_index_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_cfg_ff   <= MAGIC_RESET;
         version_cfg_ff <= VERSION_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_index)
            CSR_EXPECTED_MAGIC:   magic_cfg_ff   <= csr_pwdata[7:0];
            CSR_EXPECTED_VERSION: version_cfg_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         CSR_EXPECTED_MAGIC:   csr_prdata[7:0] = magic_cfg_ff;
         CSR_EXPECTED_VERSION: csr_prdata[7:0] = version_cfg_ff;
         default: ;
      endcase
   end

   // handshake
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign last_fire = req_fire && req_frame_end;

   // frame byte update
   assign take      = byte_index_ff < IW'(MAX_FRAME_BYTES);
   assign index_ext = 17'(byte_index_ff);
   assign in_sum    = (index_ext < 17'(CHECK_POS))
                      || ((index_ext >= 17'(HEADER_BYTES))
                          && ((index_ext - 17'(HEADER_BYTES)) < 17'(length_ff)));

   always_comb begin
      byte_index_in = byte_index_ff;
      magic_in      = magic_ff;
      version_in    = version_ff;
      type_in       = type_ff;
      sequence_in   = sequence_ff;
      length_in     = length_ff;
      check_in      = check_ff;
      xor_in        = xor_ff;
      if (take) begin
         byte_index_in = byte_index_ff + IW'(1);
         if (byte_index_ff == IW'(POS_MAGIC))    magic_in         = req_rx_byte;
         if (byte_index_ff == IW'(POS_VERSION))  version_in       = req_rx_byte;
         if (byte_index_ff == IW'(POS_TYPE))     type_in          = req_rx_byte;
         if (byte_index_ff == IW'(POS_SEQUENCE)) sequence_in      = req_rx_byte;
         if (byte_index_ff == IW'(POS_LEN_LO))   length_in[7:0]   = req_rx_byte;
         if (byte_index_ff == IW'(POS_LEN_HI))   length_in[15:8]  = req_rx_byte;
         if (byte_index_ff == IW'(CHECK_POS))    check_in         = req_rx_byte;
         if (in_sum)                             xor_in           = xor_ff ^ req_rx_byte;
      end
   end

   // verdict
   assign count_ext = 17'(byte_index_in);
   assign bytes_ext = EXTW'(byte_index_in);

   always_comb begin
      priority if (count_ext < 17'(HEADER_BYTES)) begin
         status_in = STATUS_TOO_SHORT;
      end else if (magic_in != magic_cfg_ff) begin
         status_in = STATUS_BAD_MAGIC;
      end else if (version_in != version_cfg_ff) begin
         status_in = STATUS_BAD_VERSION;
      end else if ((17'(HEADER_BYTES) + 17'(length_in)) > count_ext) begin
         status_in = STATUS_TRUNCATED;
      end else if (xor_in != check_in) begin
         status_in = STATUS_BAD_CHECK;
      end else begin
         status_in = STATUS_OK;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (last_fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= '0;
         magic_ff      <= '0;
         version_ff    <= '0;
         type_ff       <= '0;
         sequence_ff   <= '0;
         length_ff     <= '0;
         check_ff      <= '0;
         xor_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (last_fire) begin
            byte_index_ff <= '0;
            magic_ff      <= '0;
            version_ff    <= '0;
            type_ff       <= '0;
            sequence_ff   <= '0;
            length_ff     <= '0;
            check_ff      <= '0;
            xor_ff        <= '0;
         end else if (req_fire) begin
            byte_index_ff <= byte_index_in;
            magic_ff      <= magic_in;
            version_ff    <= version_in;
            type_ff       <= type_in;
            sequence_ff   <= sequence_in;
            length_ff     <= length_in;
            check_ff      <= check_in;
            xor_ff        <= xor_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (last_fire) begin
         status_ff     <= status_in;
         rsp_type_ff   <= type_in;
         rsp_seq_ff    <= sequence_in;
         rsp_length_ff <= length_in;
         rsp_bytes_ff  <= bytes_ext[6:0];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_msg_type       = rsp_type_ff;
   assign rsp_seq_number     = rsp_seq_ff;
   assign rsp_payload_length = rsp_length_ff;
   assign rsp_frame_bytes    = rsp_bytes_ff;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import phxv_pkg::*;

   localparam int FRAME_MAX    = MAX_FRAME_BYTES_DEFAULT;
   localparam int PHASE_ITEMS  = 200;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_end;
   } req_item_type;

   typedef struct {
      status_type  status;
      logic [7:0]  msg_type;
      logic [7:0]  seq_number;
      logic [15:0] payload_length;
      logic [6:0]  frame_bytes;
   } verdict_type;

   typedef enum {
      FR_GOOD,
      FR_BAD_MAGIC,
      FR_BAD_VERSION,
      FR_TRUNC,
      FR_BAD_SUM,
      FR_SHORT,
      FR_NOISE
   } frame_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid     = 1'b0;
   logic                      req_ready;
   logic [7:0]                req_rx_byte   = '0;
   logic                      req_frame_end = 1'b0;

   logic                      rsp_valid;
   logic                      rsp_ready     = 1'b0;
   logic [2:0]                rsp_status;
   logic [7:0]                rsp_msg_type;
   logic [7:0]                rsp_seq_number;
   logic [15:0]               rsp_payload_length;
   logic [6:0]                rsp_frame_bytes;

   logic                      csr_psel      = 1'b0;
   logic                      csr_penable   = 1'b0;
   logic                      csr_pwrite    = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr     = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata    = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   req_item_type pending_bytes[$];
   verdict_type  verdict_due[$];
   logic [7:0]   frame_buf[$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   logic rsp_hold = 1'b0;
   event hold_go;

   int err_count   = 0;
   int cycle_count = 0;

   // expected register contents
   logic [7:0] cfg_magic   = MAGIC_RESET;
   logic [7:0] cfg_version = VERSION_RESET;

   // frame state of the header checker copy
   int          rx_count   = 0;
   logic [7:0]  rx_magic   = '0;
   logic [7:0]  rx_version = '0;
   logic [7:0]  rx_type    = '0;
   logic [7:0]  rx_seq     = '0;
   logic [15:0] rx_length  = '0;
   logic [7:0]  rx_check   = '0;
   logic [7:0]  rx_xor     = '0;

   verdict_type  verdict_now;
   verdict_type  verdict_old;
   req_item_type next_item;

   packet_header_xor_validator u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .req_frame_end      (req_frame_end),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_msg_type       (rsp_msg_type),
      .rsp_seq_number     (rsp_seq_number),
      .rsp_payload_length (rsp_payload_length),
      .rsp_frame_bytes    (rsp_frame_bytes),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles", cycle_count);
         $display("tb: done, errors");
         $finish;
      end
   end

   task automatic note_error(input string what);
      err_count++;
      $display("tb: error at cycle %0d: %s", cycle_count, what);
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) begin
         note_error($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
      end
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_item = pending_bytes.pop_front();
            req_valid     <= 1'b1;
            req_rx_byte   <= next_item.rx_byte;
            req_frame_end <= next_item.frame_end;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // long receiver hold-off
   initial begin
      forever begin
         @(hold_go);
         rsp_hold <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         rsp_hold <= 1'b0;
      end
   end

   // header checker copy and verdict compare
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (rx_count < FRAME_MAX) begin
               case (rx_count)
                  POS_MAGIC:    rx_magic          = req_rx_byte;
                  POS_VERSION:  rx_version        = req_rx_byte;
                  POS_TYPE:     rx_type           = req_rx_byte;
                  POS_SEQUENCE: rx_seq            = req_rx_byte;
                  POS_LEN_LO:   rx_length[7:0]    = req_rx_byte;
                  POS_LEN_HI:   rx_length[15:8]   = req_rx_byte;
                  CHECK_POS:    rx_check          = req_rx_byte;
                  default: ;
               endcase
               if (rx_count < CHECK_POS ||
                   (rx_count >= HEADER_BYTES && rx_count - HEADER_BYTES < rx_length)) begin
                  rx_xor ^= req_rx_byte;
               end
               rx_count++;
            end
            if (req_frame_end) begin
               if (rx_count < HEADER_BYTES) begin
                  verdict_now.status = STATUS_TOO_SHORT;
               end else if (rx_magic != cfg_magic) begin
                  verdict_now.status = STATUS_BAD_MAGIC;
               end else if (rx_version != cfg_version) begin
                  verdict_now.status = STATUS_BAD_VERSION;
               end else if (HEADER_BYTES + rx_length > rx_count) begin
                  verdict_now.status = STATUS_TRUNCATED;
               end else if (rx_xor != rx_check) begin
                  verdict_now.status = STATUS_BAD_CHECK;
               end else begin
                  verdict_now.status = STATUS_OK;
               end
               verdict_now.msg_type       = rx_type;
               verdict_now.seq_number     = rx_seq;
               verdict_now.payload_length = rx_length;
               verdict_now.frame_bytes    = rx_count[6:0];
               verdict_due.push_back(verdict_now);
               rx_count   = 0;
               rx_magic   = '0;
               rx_version = '0;
               rx_type    = '0;
               rx_seq     = '0;
               rx_length  = '0;
               rx_check   = '0;
               rx_xor     = '0;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (verdict_due.size() == 0) begin
               note_error("verdict transfer with none expected");
            end else begin
               verdict_old = verdict_due.pop_front();
               check_field("status", 16'(rsp_status), 16'(verdict_old.status));
               check_field("msg_type", 16'(rsp_msg_type), 16'(verdict_old.msg_type));
               check_field("seq_number", 16'(rsp_seq_number), 16'(verdict_old.seq_number));
               check_field("payload_length", rsp_payload_length,
                           verdict_old.payload_length);
               check_field("frame_bytes", 16'(rsp_frame_bytes),
                           16'(verdict_old.frame_bytes));
            end
         end
      end
   end

   task automatic commit_frame;
      req_item_type it;
      foreach (frame_buf[i]) begin
         it.rx_byte   = frame_buf[i];
         it.frame_end = (i == frame_buf.size() - 1);
         pending_bytes.push_back(it);
      end
   endtask

   task automatic build_frame(input frame_kind_type kind);
      int unsigned plen;
      int unsigned n;
      logic [15:0] len_field;
      logic [7:0]  sum;
      logic [7:0]  b;
      frame_buf.delete();
      if (kind == FR_SHORT || kind == FR_NOISE) begin
         n = (kind == FR_SHORT) ? $urandom_range(HEADER_BYTES - 1, 1)
                                : $urandom_range(FRAME_MAX + 8, 1);
         repeat (n) frame_buf.push_back(8'($urandom));
      end else begin
         plen = ($urandom_range(7) == 0) ? $urandom_range(FRAME_MAX - HEADER_BYTES)
                                         : $urandom_range(12);
         len_field = 16'(plen);
         if (kind == FR_TRUNC) begin
            if ($urandom_range(1) == 1) begin
               len_field = 16'($urandom_range(16'hFFFF, FRAME_MAX - HEADER_BYTES + 1));
            end else begin
               len_field = 16'(plen + 1);
            end
         end
         frame_buf.push_back(kind == FR_BAD_MAGIC ?
                             cfg_magic ^ 8'($urandom_range(255, 1)) : cfg_magic);
         frame_buf.push_back(kind == FR_BAD_VERSION ?
                             cfg_version ^ 8'($urandom_range(255, 1)) : cfg_version);
         frame_buf.push_back(8'($urandom));
         frame_buf.push_back(8'($urandom));
         frame_buf.push_back(len_field[7:0]);
         frame_buf.push_back(len_field[15:8]);
         sum = '0;
         foreach (frame_buf[i]) sum ^= frame_buf[i];
         frame_buf.push_back(8'h00);
         repeat (plen) begin
            b = 8'($urandom);
            sum ^= b;
            frame_buf.push_back(b);
         end
         frame_buf[CHECK_POS] = (kind == FR_BAD_SUM) ? sum ^ 8'($urandom_range(255, 1)) : sum;
         // trailing bytes, sometimes past the frame limit
         if (kind != FR_TRUNC && $urandom_range(3) == 0) begin
            repeat ($urandom_range(24, 1)) frame_buf.push_back(8'($urandom));
         end
      end
      commit_frame();
   endtask

   task automatic wait_drained;
      do begin
         @(negedge clock);
      end while (pending_bytes.size() != 0 || req_valid || verdict_due.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [7:0] value);
      logic [7:0] readback;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {24'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      if (idx == CSR_EXPECTED_MAGIC) begin
         cfg_magic = value;
      end else begin
         cfg_version = value;
      end
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      while (!csr_pready) @(negedge clock);
      readback = csr_prdata[7:0];
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== value) begin
         note_error($sformatf("register %0d read 0x%0h want 0x%0h", idx, readback, value));
      end
   endtask

   task automatic run_phase(input int send_pct, input int stall_pct, input bit with_hold);
      int unsigned r;
      @(negedge clock);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      while (pending_bytes.size() < PHASE_ITEMS) begin
         r = $urandom_range(99);
         if (r < 55) begin
            build_frame(FR_GOOD);
         end else if (r < 62) begin
            build_frame(FR_BAD_MAGIC);
         end else if (r < 69) begin
            build_frame(FR_BAD_VERSION);
         end else if (r < 76) begin
            build_frame(FR_TRUNC);
         end else if (r < 84) begin
            build_frame(FR_BAD_SUM);
         end else if (r < 92) begin
            build_frame(FR_SHORT);
         end else begin
            build_frame(FR_NOISE);
         end
      end
      if (with_hold) begin
         -> hold_go;
      end
      wait_drained();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      // one byte frame, all header fields but magic still zero
      frame_buf = '{8'hFF};
      commit_frame();
      // header cut before the check byte
      frame_buf = '{MAGIC_RESET, VERSION_RESET, 8'hFF, 8'h00, 8'hFF, 8'hFF};
      commit_frame();
      // empty payload, good check
      frame_buf = '{MAGIC_RESET, VERSION_RESET, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h31};
      commit_frame();
      // one payload byte, check off by one bit
      frame_buf = '{MAGIC_RESET, VERSION_RESET, 8'h7E, 8'h81, 8'h01, 8'h00, 8'hB1, 8'h80};
      commit_frame();
      wait_drained();

      csr_write(CSR_EXPECTED_MAGIC, 8'h00);
      csr_write(CSR_EXPECTED_VERSION, 8'hFF);
      run_phase(0, 0, 1'b1);

      csr_write(CSR_EXPECTED_MAGIC, 8'hFF);
      csr_write(CSR_EXPECTED_VERSION, 8'h00);
      run_phase(45, 0, 1'b0);

      csr_write(CSR_EXPECTED_MAGIC, 8'($urandom));
      csr_write(CSR_EXPECTED_VERSION, 8'($urandom));
      run_phase(0, 45, 1'b0);

      csr_write(CSR_EXPECTED_MAGIC, MAGIC_RESET);
      csr_write(CSR_EXPECTED_VERSION, 8'($urandom));
      run_phase(35, 35, 1'b0);

      if (verdict_due.size() != 0) begin
         note_error($sformatf("%0d verdicts never arrived", verdict_due.size()));
      end
      if (err_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
